FILE: rtl/core/rprs_pkg.sv
// Shared types and opcodes for the received packet range set.
`timescale 1ns / 1ps
package rprs_pkg;
    localparam int PN_W = 62;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef logic [PN_W-1:0] pn_t;

    typedef struct packed {
        logic [1:0] opcode;
        pn_t        pn;
        logic       below_floor;
    } cmd_t;

    typedef struct packed {
        logic flag;
        pn_t  range_low;
        pn_t  range_high;
        logic range_valid;
        logic last;
    } res_t;
endpackage

FILE: rtl/core/rprs_if.sv
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps
interface rprs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/received_packet_range_set.sv
// Top level of the received packet range set.
// Usage:
//   cmd channel (sink): opcode + packet_number per transaction.
//     record, delete-below, duplicate query, read ranges.
//   rsp channel (source): flag, range_low, range_high, range_valid, last.
//   Record, delete and query give one response; read gives one per interval,
//   highest first, or one empty response with last set when the set is empty.
// Sequencing:
//   A two-entry queue decouples command intake from the back end sequencer.
//   Record and query scan one interval per cycle from the top; a record
//   may then shift slots on insert or close the gap after a merge.
//   Each command waits in the queue until the sequencer takes it.
//   Delete drops one interval per cycle. Read emits one interval per cycle
//   while the response is not held.
//   Commands are carried out one at a time by the sequencer.
// Reset:
//   rst_n clears the set (no intervals) and the floor to zero.
// Stall:
//   A held response stalls the sequencer; the queue keeps accepting
//   commands until it is full.
`timescale 1ns / 1ps
module received_packet_range_set
    import rprs_pkg::*;
#(
    parameter int RANGE_LIMIT = 32
)
(
    input logic clk,
    input logic rst_n,
    rprs_if.sink   cmd,
    rprs_if.source rsp
);
    logic q_valid, q_ready;
    cmd_t q_cmd;
    pn_t  floor_val;
    res_t res;

    rprs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(cmd.valid), .in_ready(cmd.ready),
        .in_opcode(cmd.data.opcode), .in_pn(cmd.data.pn),
        .floor_val(floor_val),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    rprs_back #(.RANGE_LIMIT(RANGE_LIMIT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .floor_val(floor_val),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_res(res)
    );

    assign rsp.data = res;

`ifndef SYNTHESIS
    // non-last responses only come from readout with a valid interval
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.last |-> rsp.data.range_valid)
        else $error("non-final response without interval");
    // flag and interval are never both set
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.flag && rsp.data.range_valid))
        else $error("flag set on readout response");
    // stalled response holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("response dropped under stall");
`endif
endmodule

FILE: rtl/core/rprs_front.sv
// Front end: accepts commands, checks them against the floor, queues them.
`timescale 1ns / 1ps
module rprs_front
    import rprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_opcode,
    input  pn_t         in_pn,
    input  pn_t         floor_val,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    // two-entry queue
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rd_ptr_reg];

    // floor is checked again in the back end, since a queued delete may raise it
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{opcode: in_opcode, pn: in_pn,
                                     below_floor: (in_pn < floor_val)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: rtl/core/rprs_back.sv
// Back end: interval store and the sequencer that walks it one slot per cycle while the response is not held.
`timescale 1ns / 1ps
module rprs_back
    import rprs_pkg::*;
#(
    parameter int RANGE_LIMIT = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output pn_t  floor_val,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);
    localparam int IW = (RANGE_LIMIT > 1) ? $clog2(RANGE_LIMIT) : 1;
    localparam int CW = $clog2(RANGE_LIMIT + 1);
    localparam logic [CW-1:0] LIMIT_C = CW'(RANGE_LIMIT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_DEL   = 3'd5;

    pn_t            st_reg [RANGE_LIMIT];
    pn_t            en_reg [RANGE_LIMIT];
    logic [CW-1:0]  cnt_reg;
    pn_t            floor_reg;
    logic [2:0]     state_reg;
    logic [1:0]     op_reg;
    pn_t            pn_reg;
    logic [CW-1:0]  idx_reg;   // slot under test (scan) or shift cursor
    logic [CW-1:0]  pos_reg;   // insertion slot
    logic           out_v_reg;
    res_t           res_reg;

    logic [IW-1:0]  j;
    pn_t            s_j, e_j, e_prev;
    logic           out_free;
    logic           emit;

    assign floor_val = floor_reg;
    assign out_valid = out_v_reg;
    assign out_res   = res_reg;
    assign out_free  = !out_v_reg || out_ready;
    assign emit      = out_free && (state_reg == S_OUT || state_reg == S_READ);
    assign q_ready   = (state_reg == S_IDLE) && out_free;
    assign j         = IW'(idx_reg - 1'b1);
    assign s_j       = st_reg[j];
    assign e_j       = en_reg[j];
    assign e_prev    = en_reg[IW'(idx_reg - 2'd2)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            floor_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (emit) out_v_reg <= 1'b1;
            else if (out_ready) out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && out_free)
                    begin
                        op_reg  <= q_cmd.opcode;
                        pn_reg  <= q_cmd.pn;
                        idx_reg <= cnt_reg;
                        case (q_cmd.opcode)
                            OP_RECORD: state_reg <= (q_cmd.pn < floor_reg) ? S_OUT : S_SCAN;
                            OP_DELETE:
                            begin
                                if (q_cmd.pn >= floor_reg)
                                begin
                                    floor_reg <= q_cmd.pn;
                                    state_reg <= S_DEL;
                                end
                                else state_reg <= S_OUT;
                            end
                            OP_QUERY:
                            begin
                                if (q_cmd.pn < floor_reg) state_reg <= S_OUT;
                                else state_reg <= S_SCAN;
                            end
                            default: state_reg <= S_READ;
                        endcase
                        // below the floor counts as seen for a query
                        res_reg.flag        <= (q_cmd.opcode == OP_QUERY) &&
                                               (q_cmd.pn < floor_reg);
                        res_reg.range_low   <= '0;
                        res_reg.range_high  <= '0;
                        res_reg.range_valid <= 1'b0;
                        res_reg.last        <= 1'b1;
                    end
                end
                // walk slots from highest to lowest
                S_SCAN:
                begin
                    if (op_reg == OP_QUERY)
                    begin
                        if (idx_reg == '0) state_reg <= S_OUT;
                        else if (pn_reg >= s_j && pn_reg <= e_j)
                        begin
                            res_reg.flag <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else idx_reg <= idx_reg - 1'b1;
                    end
                    else if (idx_reg == '0)
                    begin
                        res_reg.flag <= 1'b1;
                        pos_reg <= '0;
                        idx_reg <= cnt_reg;
                        state_reg <= S_SHIFT;
                    end
                    else if (pn_reg >= s_j && pn_reg <= e_j) state_reg <= S_OUT;
                    else if (pn_reg != '0 && e_j == pn_reg - 1'b1)
                    begin
                        en_reg[j] <= pn_reg;
                        res_reg.flag <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    // one bit wider so the top number does not wrap to zero
                    else if ({1'b0, s_j} == {1'b0, pn_reg} + 63'd1)
                    begin
                        st_reg[j] <= pn_reg;
                        res_reg.flag <= 1'b1;
                        if (idx_reg > 1 && e_prev + 1'b1 == pn_reg)
                        begin
                            // merge: lower slot absorbs this one, close the gap
                            en_reg[IW'(idx_reg - 2'd2)] <= e_j;
                            cnt_reg <= cnt_reg - 1'b1;
                            state_reg <= S_DEL;
                            op_reg <= OP_RECORD;
                        end
                        else state_reg <= S_OUT;
                    end
                    else if (pn_reg > e_j)
                    begin
                        res_reg.flag <= 1'b1;
                        pos_reg <= idx_reg;
                        idx_reg <= cnt_reg;
                        state_reg <= S_SHIFT;
                    end
                    else idx_reg <= idx_reg - 1'b1;
                end
                // open a slot at pos_reg, dropping the lowest when full
                S_SHIFT:
                begin
                    if (cnt_reg == LIMIT_C)
                    begin
                        if (pos_reg == '0) state_reg <= S_OUT;
                        else
                        begin
                            // shift slots 1..pos-1 down by one
                            pos_reg <= pos_reg - 1'b1;
                            cnt_reg <= cnt_reg - 1'b1;
                            idx_reg <= '0;
                            op_reg  <= OP_READ;
                        end
                    end
                    else if (op_reg == OP_READ)
                    begin
                        if (idx_reg == pos_reg)
                        begin
                            st_reg[IW'(idx_reg)] <= pn_reg;
                            en_reg[IW'(idx_reg)] <= pn_reg;
                            cnt_reg <= LIMIT_C;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            st_reg[IW'(idx_reg)] <= st_reg[IW'(idx_reg + 1'b1)];
                            en_reg[IW'(idx_reg)] <= en_reg[IW'(idx_reg + 1'b1)];
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else if (idx_reg == pos_reg)
                    begin
                        st_reg[IW'(idx_reg)] <= pn_reg;
                        en_reg[IW'(idx_reg)] <= pn_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        st_reg[IW'(idx_reg)] <= s_j;
                        en_reg[IW'(idx_reg)] <= e_j;
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                // delete: drop lowest slots below the floor, trim a straddling one; record-merge: close gap
                S_DEL:
                begin
                    if (op_reg == OP_RECORD)
                    begin
                        // idx_reg-1 was the merged slot; shift everything above down
                        if (idx_reg >= cnt_reg + 1'b1)
                            state_reg <= S_OUT;
                        else
                        begin
                            st_reg[j] <= st_reg[IW'(idx_reg)];
                            en_reg[j] <= en_reg[IW'(idx_reg)];
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else if (cnt_reg != '0 && en_reg[0] < pn_reg)
                    begin
                        for (int k = 0; k < RANGE_LIMIT - 1; k++)
                        begin
                            st_reg[k] <= st_reg[k+1];
                            en_reg[k] <= en_reg[k+1];
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        if (cnt_reg != '0 && st_reg[0] < pn_reg) st_reg[0] <= pn_reg;
                        state_reg <= S_OUT;
                    end
                end
                // readout, one interval per transaction
                S_READ:
                begin
                    if (out_free)
                    begin
                        if (idx_reg == '0) state_reg <= S_IDLE;
                        else
                        begin
                            res_reg.range_low   <= s_j;
                            res_reg.range_high  <= e_j;
                            res_reg.range_valid <= 1'b1;
                            res_reg.last        <= (idx_reg == 1);
                            idx_reg <= idx_reg - 1'b1;
                            if (idx_reg == 1) state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the received packet range set: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench;
    import rprs_pkg::*;

    localparam int SLOTS = 32;
    localparam logic [63:0] PN_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    rprs_if #(.T(cmd_t)) cmd_ch ();
    rprs_if #(.T(res_t)) rsp_ch ();

    received_packet_range_set #(.RANGE_LIMIT(SLOTS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Clock and reset
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the interval set
    logic [63:0] iv_lo [SLOTS];
    logic [63:0] iv_hi [SLOTS];
    int          iv_count;
    logic [63:0] floor_pn;

    // Expected responses, in order, indexed by running counters
    res_t        exp_buf [int];
    int          exp_wr;
    int          exp_rd;
    int          err_count;
    int          send_idle_pct;
    int          rsp_stall_pct;

    function automatic void exp_put(res_t r);
        exp_buf[exp_wr] = r;
        exp_wr++;
    endfunction

    function automatic void drop_slot(int pos);
        if (pos >= iv_count) return;
        for (int k = pos; k + 1 < iv_count; k++)
        begin
            iv_lo[k] = iv_lo[k+1];
            iv_hi[k] = iv_hi[k+1];
        end
        iv_count--;
    endfunction

    function automatic void open_interval(int pos, logic [63:0] pn);
        int p;
        p = (pos > iv_count) ? iv_count : pos;
        if (iv_count >= SLOTS)
        begin
            if (p == 0) return;     // new interval is the lowest: lost on overflow
            drop_slot(0);
            p--;
        end
        for (int k = iv_count; k > p; k--)
        begin
            iv_lo[k] = iv_lo[k-1];
            iv_hi[k] = iv_hi[k-1];
        end
        iv_lo[p] = pn;
        iv_hi[p] = pn;
        iv_count++;
    endfunction

    function automatic logic record_pn(logic [63:0] pn);
        int j;
        if (pn < floor_pn) return 1'b0;
        for (int i = iv_count; i > 0; i--)
        begin
            j = i - 1;
            if (pn >= iv_lo[j] && pn <= iv_hi[j]) return 1'b0;
            if (pn > 0 && iv_hi[j] == pn - 1)
            begin
                iv_hi[j] = pn;
                return 1'b1;
            end
            if (iv_lo[j] == pn + 1)
            begin
                iv_lo[j] = pn;
                if (j > 0 && iv_hi[j-1] + 1 == pn)
                begin
                    iv_hi[j-1] = iv_hi[j];
                    drop_slot(j);
                end
                return 1'b1;
            end
            if (pn > iv_hi[j])
            begin
                open_interval(j + 1, pn);
                return 1'b1;
            end
        end
        open_interval(0, pn);
        return 1'b1;
    endfunction

    function automatic logic seen_pn(logic [63:0] pn);
        if (pn < floor_pn) return 1'b1;
        for (int i = 0; i < iv_count; i++)
            if (pn >= iv_lo[i] && pn <= iv_hi[i]) return 1'b1;
        return 1'b0;
    endfunction

    // Update the shadow set and queue the responses one command yields
    function automatic void predict_cmd(logic [1:0] op, logic [63:0] pn);
        res_t r;
        r = '0;
        r.last = 1'b1;
        case (op)
            OP_RECORD: r.flag = record_pn(pn);
            OP_DELETE:
            begin
                if (pn >= floor_pn)
                begin
                    floor_pn = pn;
                    while (iv_count > 0 && iv_hi[0] < pn) drop_slot(0);
                    if (iv_count > 0 && iv_lo[0] < pn) iv_lo[0] = pn;
                end
            end
            OP_QUERY: r.flag = seen_pn(pn);
            default:
            begin
                if (iv_count > 0)
                begin
                    for (int i = iv_count; i > 0; i--)
                    begin
                        r = '0;
                        r.range_low   = iv_lo[i-1][PN_W-1:0];
                        r.range_high  = iv_hi[i-1][PN_W-1:0];
                        r.range_valid = 1'b1;
                        r.last        = (i == 1);
                        exp_put(r);
                    end
                    return;
                end
            end
        endcase
        exp_put(r);
    endfunction

    // Drive one command and hold it until the block takes it
    task automatic send_cmd(logic [1:0] op, logic [63:0] pn, bit typed, logic typed_flag);
        int gap;
        int before_n;
        before_n = exp_wr;
        predict_cmd(op, pn);
        if (typed && op != OP_READ)
            exp_buf[before_n].flag = typed_flag;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.data.opcode <= op;
        cmd_ch.data.pn     <= pn[PN_W-1:0];
        do @(posedge clk); while (!cmd_ch.ready);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_rsp();
        cmd_ch.valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        @(posedge clk);
    endtask

    // Response sink with random back-pressure
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Response checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("unexpected response %h", rsp_ch.data);
                err_count++;
            end
            else
            begin
                want = exp_buf[exp_rd];
                exp_buf.delete(exp_rd);
                exp_rd++;
                if (rsp_ch.data.flag !== want.flag)
                begin
                    $error("flag exp %h got %h", want.flag, rsp_ch.data.flag);
                    err_count++;
                end
                if (rsp_ch.data.range_low !== want.range_low)
                begin
                    $error("range_low exp %h got %h", want.range_low, rsp_ch.data.range_low);
                    err_count++;
                end
                if (rsp_ch.data.range_high !== want.range_high)
                begin
                    $error("range_high exp %h got %h", want.range_high, rsp_ch.data.range_high);
                    err_count++;
                end
                if (rsp_ch.data.range_valid !== want.range_valid)
                begin
                    $error("range_valid exp %h got %h", want.range_valid,
                           rsp_ch.data.range_valid);
                    err_count++;
                end
                if (rsp_ch.data.last !== want.last)
                begin
                    $error("last exp %h got %h", want.last, rsp_ch.data.last);
                    err_count++;
                end
            end
        end
    end

    // Directed table: typed flag only where it is obvious
    typedef struct {
        logic [1:0]  op;
        logic [63:0] pn;
        bit          typed;
        logic        flag;
    } dir_row_t;

    dir_row_t dir_tab[] = '{
        '{OP_READ,   64'd0,       1, 1'b0},   // empty readout
        '{OP_QUERY,  64'd0,       1, 1'b0},
        '{OP_RECORD, PN_MAX,      1, 1'b1},   // top of range
        '{OP_RECORD, PN_MAX,      1, 1'b0},   // already covered
        '{OP_RECORD, 64'd0,       1, 1'b1},
        '{OP_QUERY,  64'd0,       1, 1'b1},
        '{OP_RECORD, 64'd1,       0, 1'b0},   // extends upward
        '{OP_RECORD, 64'd3,       0, 1'b0},
        '{OP_RECORD, 64'd2,       0, 1'b0},   // merges neighbors
        '{OP_RECORD, PN_MAX - 2,  0, 1'b0},
        '{OP_RECORD, PN_MAX - 1,  0, 1'b0},   // merge at the top
        '{OP_READ,   64'd0,       0, 1'b0},
        '{OP_DELETE, 64'd2,       1, 1'b0},   // trims straddling interval
        '{OP_RECORD, 64'd1,       1, 1'b0},   // below floor
        '{OP_QUERY,  64'd1,       1, 1'b1},
        '{OP_DELETE, 64'd1,       1, 1'b0},   // lower than floor: ignored
        '{OP_RECORD, 64'd6,       0, 1'b0},
        '{OP_RECORD, 64'd5,       0, 1'b0},   // extends downward
        '{OP_QUERY,  64'd4,       0, 1'b0},
        '{OP_READ,   64'd0,       0, 1'b0},
        '{OP_DELETE, 64'd7,       1, 1'b0},   // drops two whole intervals
        '{OP_READ,   64'd0,       0, 1'b0},
        '{OP_DELETE, PN_MAX,      1, 1'b0},
        '{OP_QUERY,  PN_MAX - 1,  1, 1'b1},
        '{OP_READ,   64'd0,       0, 1'b0}
    };

    initial
    begin
        logic [63:0] base;
        logic [63:0] pn;
        logic [1:0]  op;
        int          pick;

        err_count     = 0;
        exp_wr        = 0;
        exp_rd        = 0;
        iv_count      = 0;
        floor_pn      = '0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.data   = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            iv_lo[k] = '0;
            iv_hi[k] = '0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_cmd(dir_tab[i].op, dir_tab[i].pn, dir_tab[i].typed, dir_tab[i].flag);
        drain_rsp();

        // Random traffic in four idle/stall phases, each with fresh windows
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 60; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 60; end
                default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
            endcase
            for (int w = 0; w < 2; w++)
            begin
                pick = $urandom_range(2);
                if (pick == 0)      base = floor_pn;
                else if (pick == 1) base = PN_MAX - 200;
                else                base = {$urandom, $urandom} & (PN_MAX - 64'd255);
                if (base < floor_pn) base = floor_pn;
                if (base > PN_MAX - 200) base = PN_MAX - 200;
                for (int n = 0; n < 28; n++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 60)      op = OP_RECORD;
                    else if (pick < 75) op = OP_QUERY;
                    else if (pick < 85) op = OP_READ;
                    else                op = OP_DELETE;
                    if ($urandom_range(9) == 0)
                        pn = {$urandom, $urandom} & PN_MAX;
                    else if (op == OP_DELETE)
                        pn = base + $urandom_range(40);
                    else if ($urandom_range(1) == 0)
                        pn = base + 2 * $urandom_range(90);   // spread: can drive the set to overflow
                    else
                        pn = base + $urandom_range(180);
                    send_cmd(op, pn, 0, 1'b0);
                end
            end
            // Hold the sender until the block has caught up
            drain_rsp();
        end

        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
